// ----- src/rek_pkg.sv -----
// Shared types, register codes and the encoder phase table for the setpoint knob.
package rek_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VALUE_MIN   = 3'd0,
		REG_VALUE_MAX   = 3'd1,
		REG_STEP_SIZE   = 3'd2,
		REG_WRAP        = 3'd3,
		REG_SWAP        = 3'd4,
		REG_START_VALUE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		DETENT_NONE = 2'd0,
		DETENT_CW   = 2'd1,
		DETENT_CCW  = 2'd2
	} detent_t;

	localparam logic [7:0] DIR_CW_FLAG  = 8'h10;
	localparam logic [7:0] DIR_CCW_FLAG = 8'h20;
	localparam logic [7:0] PHASE_MASK   = 8'h0f;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN_RST = 32'sd0;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX_RST = 32'sd90000;
	localparam logic [STEP_W-1:0]         STEP_RST      = 16'd100;
	localparam logic signed [VALUE_W-1:0] START_RST     = 32'sd0;

	// Full-step table; the unused phase code repeats the start row.
	localparam logic [7:0] PHASE_TABLE [8][4] = '{
		'{8'h00, 8'h02, 8'h04, 8'h00},
		'{8'h03, 8'h00, 8'h01, 8'h10},
		'{8'h03, 8'h02, 8'h00, 8'h00},
		'{8'h03, 8'h02, 8'h01, 8'h00},
		'{8'h06, 8'h00, 8'h04, 8'h00},
		'{8'h06, 8'h05, 8'h00, 8'h20},
		'{8'h06, 8'h05, 8'h04, 8'h00},
		'{8'h00, 8'h02, 8'h04, 8'h00}
	};

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_min;
		logic signed [VALUE_W-1:0] value_max;
		logic [STEP_W-1:0]         step_size;
		logic                      wrap_at_limits;
		logic                      swap_direction;
		logic signed [VALUE_W-1:0] start_value;
		logic                      start_load;
	} cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		detent_t    detent;
	} phase_step_t;

	function automatic phase_step_t phase_lookup(input logic [2:0] phase, input logic [1:0] pins);
		logic [7:0]  entry;
		phase_step_t r;
		entry = PHASE_TABLE[phase][pins];
		r.phase = entry[2:0] & PHASE_MASK[2:0];
		if ((entry & DIR_CW_FLAG) != 8'h00) begin
			r.detent = DETENT_CW;
		end else if ((entry & DIR_CCW_FLAG) != 8'h00) begin
			r.detent = DETENT_CCW;
		end else begin
			r.detent = DETENT_NONE;
		end
		return r;
	endfunction

endpackage

// ----- src/rek_cfg.sv -----
// Configuration register file of the setpoint knob.
module rek_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rek_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rek_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rek_pkg::cfg_t                   cfg
);

	logic signed [rek_pkg::VALUE_W-1:0] value_min_q;
	logic signed [rek_pkg::VALUE_W-1:0] value_max_q;
	logic [rek_pkg::STEP_W-1:0]         step_size_q;
	logic                               wrap_q;
	logic                               swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q   <= rek_pkg::VALUE_MIN_RST;
			value_max_q   <= rek_pkg::VALUE_MAX_RST;
			step_size_q   <= rek_pkg::STEP_RST;
			wrap_q        <= 1'b0;
			swap_q        <= 1'b0;
		end else if (cfg_we) begin
			case (rek_pkg::reg_idx_t'(cfg_idx))
				rek_pkg::REG_VALUE_MIN:   value_min_q   <= cfg_data;
				rek_pkg::REG_VALUE_MAX:   value_max_q   <= cfg_data;
				rek_pkg::REG_STEP_SIZE:   step_size_q   <= cfg_data[rek_pkg::STEP_W-1:0];
				rek_pkg::REG_WRAP:        wrap_q        <= cfg_data[0];
				rek_pkg::REG_SWAP:        swap_q        <= cfg_data[0];
				// the preset only matters at the write, where it loads the setpoint
				rek_pkg::REG_START_VALUE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.value_min      = value_min_q;
		cfg.value_max      = value_max_q;
		cfg.step_size      = step_size_q;
		cfg.wrap_at_limits = wrap_q;
		cfg.swap_direction = swap_q;
		// the preset goes straight to the setpoint in the same edge as the write
		cfg.start_value    = cfg_data;
		cfg.start_load     = cfg_we && (cfg_idx == rek_pkg::REG_START_VALUE);
	end

endmodule

// ----- src/rek_step.sv -----
// Phase table step and bounded setpoint move for one pin sample.
module rek_step (
	input  rek_pkg::cfg_t                       cfg,
	input  logic [2:0]                          phase,
	input  logic signed [rek_pkg::VALUE_W-1:0]  value,
	input  logic [1:0]                          pins,
	input  logic                                clear_value,
	output logic [2:0]                          next_phase,
	output logic signed [rek_pkg::VALUE_W-1:0]  next_value,
	output rek_pkg::detent_t                    detent,
	output logic                                changed
);

	rek_pkg::phase_step_t ps;
	logic                 up;
	logic signed [33:0]   value_x;
	logic signed [33:0]   step_x;
	logic signed [33:0]   cand;
	logic signed [33:0]   min_x;
	logic signed [33:0]   max_x;
	logic                 in_range;
	logic signed [rek_pkg::VALUE_W-1:0] moved;

	always_comb begin
		ps         = rek_pkg::phase_lookup(phase, pins);
		next_phase = ps.phase;
		detent     = ps.detent;
		up         = (ps.detent == rek_pkg::DETENT_CW) ^ cfg.swap_direction;
		value_x    = {{2{value[rek_pkg::VALUE_W-1]}}, value};
		step_x     = {18'd0, cfg.step_size};
		min_x      = {{2{cfg.value_min[rek_pkg::VALUE_W-1]}}, cfg.value_min};
		max_x      = {{2{cfg.value_max[rek_pkg::VALUE_W-1]}}, cfg.value_max};
		cand       = up ? (value_x + step_x) : (value_x - step_x);
		in_range   = (cand >= min_x) && (cand <= max_x);
		if (ps.detent == rek_pkg::DETENT_NONE) begin
			moved = value;
		end else if (in_range) begin
			moved = cand[rek_pkg::VALUE_W-1:0];
		end else if (cfg.wrap_at_limits) begin
			moved = up ? cfg.value_min : cfg.value_max;
		end else begin
			moved = value;
		end
		next_value = clear_value ? '0 : moved;
		changed    = (next_value != value);
	end

endmodule

// ----- src/rotary_encoder_setpoint_knob.sv -----
// Top level of the quadrature rotary encoder setpoint knob.
//
//  channel | direction | handshake           | payload (low bit up)
//  --------+-----------+---------------------+----------------------------------------
//  s_*     | in        | s_tvalid / s_tready | pin_pair[1:0], clear_value
//  m_*     | out       | m_tvalid / m_tready | setpoint[31:0], detent[1:0], changed
//  cfg_*   | in        | cfg_we (no wait)    | cfg_idx selects register, cfg_data value
//
// One request per cycle sustained while results are taken; each passes the input
// register s1 and the result register s2. The loop through the phase table and the
// 34-bit add and limit compare is combinational on the encoder and setpoint state.
// Reset clears the phase to start and loads the setpoint with the start preset (0).
// A stalled result holds in s2 while s1 keeps the next request; input stalls only when
// both are full. Writing start_value loads the setpoint in the same edge.
module rotary_encoder_setpoint_knob (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rek_pkg::IN_TDATA_W-1:0]    s_tdata,   // pin_pair[1:0], clear_value[2]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rek_pkg::OUT_TDATA_W-1:0]   m_tdata,   // setpoint[31:0], detent[33:32], changed[34]
	input  logic                              cfg_we,
	input  logic [rek_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rek_pkg::CFG_DATA_W-1:0]    cfg_data
);

	rek_pkg::cfg_t cfg;

	// input stage
	logic       valid_s1;
	logic [1:0] pins_s1;
	logic       clear_s1;

	// result stage
	logic                               valid_s2;
	logic signed [rek_pkg::VALUE_W-1:0] setpoint_s2;
	rek_pkg::detent_t                   detent_s2;
	logic                               changed_s2;

	// knob state
	logic [2:0]                         phase_q;
	logic signed [rek_pkg::VALUE_W-1:0] setpoint_q;

	logic                               in_fire;
	logic                               s1_fire;
	logic [2:0]                         next_phase;
	logic signed [rek_pkg::VALUE_W-1:0] next_value;
	rek_pkg::detent_t                   detent;
	logic                               changed;

	rek_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rek_step u_step (
		.cfg         (cfg),
		.phase       (phase_q),
		.value       (setpoint_q),
		.pins        (pins_s1),
		.clear_value (clear_s1),
		.next_phase  (next_phase),
		.next_value  (next_value),
		.detent      (detent),
		.changed     (changed)
	);

	// advance s1 into s2 whenever s2 is empty or being drained
	assign s1_fire  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_fire;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pins_s1  <= s_tdata[1:0];
			clear_s1 <= s_tdata[2];
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			setpoint_s2 <= next_value;
			detent_s2   <= detent;
			changed_s2  <= changed;
		end
	end

	// knob state: a preset write wins, otherwise advance on each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 3'd0;
			setpoint_q <= rek_pkg::START_RST;
		end else if (cfg.start_load) begin
			setpoint_q <= cfg.start_value;
		end else if (s1_fire) begin
			phase_q    <= next_phase;
			setpoint_q <= next_value;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, changed_s2, detent_s2, setpoint_s2};

	// the unused phase code is never entered
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 3'd7)
		else $error("encoder phase reached unused code");

	// detent code three never leaves the block
	a_detent_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (detent_s2 != 2'd3))
		else $error("illegal detent code in result");

	// no detent and no clear leaves the setpoint untouched
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !cfg.start_load && (detent == rek_pkg::DETENT_NONE) && !clear_s1)
		|=> (setpoint_q == $past(setpoint_q)))
		else $error("setpoint moved without detent");

	// clear forces zero
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !cfg.start_load && clear_s1) |=> (setpoint_q == '0))
		else $error("clear did not zero setpoint");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the rotary encoder setpoint knob.
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic       clr;
		logic [1:0] pins;
	} knob_sample_t;

	typedef struct {
		logic signed [rek_pkg::VALUE_W-1:0] setpoint;
		rek_pkg::detent_t                   detent;
		logic                               changed;
	} knob_result_t;

	// Next encoder phase per current phase and pin pair; the unused code behaves as start.
	localparam logic [2:0] PHASE_NEXT [8][4] = '{
		'{3'd0, 3'd2, 3'd4, 3'd0},
		'{3'd3, 3'd0, 3'd1, 3'd0},
		'{3'd3, 3'd2, 3'd0, 3'd0},
		'{3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd6, 3'd0, 3'd4, 3'd0},
		'{3'd6, 3'd5, 3'd0, 3'd0},
		'{3'd6, 3'd5, 3'd4, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd0}
	};

	// Opening samples, {clear, pins}: turns both ways, a hold at the lower limit,
	// a broken turn, clear at rest and clear on the detent edge.
	localparam logic [2:0] OPENING [25] = '{
		3'b001, 3'b000, 3'b010, 3'b011,
		3'b010, 3'b000, 3'b001, 3'b011,
		3'b010, 3'b000, 3'b001, 3'b011,
		3'b001, 3'b000, 3'b001, 3'b011,
		3'b001, 3'b000, 3'b010, 3'b011,
		3'b111,
		3'b001, 3'b000, 3'b010, 3'b111
	};

	logic                            clk;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rek_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rek_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_we   = 1'b0;
	logic [rek_pkg::CFG_IDX_W-1:0]   cfg_idx  = '0;
	logic [rek_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Knob state as the block should hold it.
	longint     lim_lo     = longint'(rek_pkg::VALUE_MIN_RST);
	longint     lim_hi     = longint'(rek_pkg::VALUE_MAX_RST);
	longint     step_amt   = longint'(rek_pkg::STEP_RST);
	logic       wrap_en    = 1'b0;
	logic       swap_en    = 1'b0;
	logic [2:0] knob_phase = 3'd0;
	longint     knob_value = longint'(rek_pkg::START_RST);

	knob_sample_t pin_samples[$];
	knob_result_t knob_results_due[$];
	int           samples_unaccepted = 0;
	int           fail_count = 0;
	bit           sample_taken = 1'b0;
	int unsigned  src_idle_pct = 0;
	int unsigned  sink_stall_pct = 0;

	rotary_encoder_setpoint_knob u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// Step the knob by one pin sample and return what the block should report.
	function automatic knob_result_t turn_knob(input logic [1:0] pins, input logic clr);
		knob_result_t r;
		longint       was;
		longint       moved;
		logic         up;
		was = knob_value;
		r.detent = rek_pkg::DETENT_NONE;
		if (pins == 2'd3 && knob_phase == 3'd1) begin
			r.detent = rek_pkg::DETENT_CW;
		end else if (pins == 2'd3 && knob_phase == 3'd5) begin
			r.detent = rek_pkg::DETENT_CCW;
		end
		knob_phase = PHASE_NEXT[knob_phase][pins];
		if (r.detent != rek_pkg::DETENT_NONE) begin
			up = (r.detent == rek_pkg::DETENT_CW) ^ swap_en;
			moved = up ? knob_value + step_amt : knob_value - step_amt;
			// a move landing exactly on a limit is taken
			if (moved >= lim_lo && moved <= lim_hi) begin
				knob_value = moved;
			end else if (wrap_en) begin
				knob_value = up ? lim_lo : lim_hi;
			end
		end
		if (clr) begin
			knob_value = 0;
		end
		r.setpoint = knob_value[31:0];
		r.changed  = (knob_value != was);
		return r;
	endfunction

	function automatic void post_sample(input logic [1:0] pins, input logic clr);
		knob_sample_t smp;
		smp.pins = pins;
		smp.clr  = clr;
		pin_samples.push_back(smp);
		samples_unaccepted++;
	endfunction

	// Predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		knob_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				knob_results_due.push_back(turn_knob(s_tdata[1:0], s_tdata[2]));
				samples_unaccepted--;
				sample_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (knob_results_due.size() == 0) begin
					fail_count++;
					$error("result with none expected: tdata %h", m_tdata);
				end else begin
					want = knob_results_due.pop_front();
					if ($signed(m_tdata[31:0]) != want.setpoint) begin
						fail_count++;
						$error("setpoint: expected %0d, got %0d", want.setpoint,
							$signed(m_tdata[31:0]));
					end
					if (m_tdata[33:32] != want.detent) begin
						fail_count++;
						$error("detent: expected %0d, got %0d", want.detent, m_tdata[33:32]);
					end
					if (m_tdata[34] != want.changed) begin
						fail_count++;
						$error("changed: expected %0d, got %0d", want.changed, m_tdata[34]);
					end
				end
			end
		end
	end

	// Hold a request until it is taken, then advance or idle; stall the result side.
	always @(negedge clk) begin
		knob_sample_t smp;
		if (arst_n) begin
			if (!s_tvalid || sample_taken) begin
				if (pin_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					smp = pin_samples.pop_front();
					s_tdata  <= {5'd0, smp.clr, smp.pins};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
		sample_taken = 1'b0;
	end

	// Write all registers back to back; start value goes last and loads the setpoint.
	task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
			input logic [15:0] step, input logic wrap, input logic swap,
			input logic [31:0] start);
		logic [31:0]       vals [6];
		rek_pkg::reg_idx_t regs [6];
		vals = '{lo, hi, {16'd0, step}, {31'd0, wrap}, {31'd0, swap}, start};
		regs = '{rek_pkg::REG_VALUE_MIN, rek_pkg::REG_VALUE_MAX, rek_pkg::REG_STEP_SIZE,
			rek_pkg::REG_WRAP, rek_pkg::REG_SWAP, rek_pkg::REG_START_VALUE};
		for (int i = 0; i < 6; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= regs[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		lim_lo     = longint'($signed(lo));
		lim_hi     = longint'($signed(hi));
		step_amt   = longint'(step);
		wrap_en    = wrap;
		swap_en    = swap;
		knob_value = longint'($signed(start));
	endtask

	// Mostly full detents with contact bounce, some broken turns and pin noise.
	task automatic queue_turns(input int n, input int unsigned cw_pct);
		logic [1:0] seq [4];
		int         made;
		int         r;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if ($urandom_range(99) < cw_pct) begin
				seq = '{2'd1, 2'd0, 2'd2, 2'd3};
			end else begin
				seq = '{2'd2, 2'd0, 2'd1, 2'd3};
			end
			if (r < 75) begin
				for (int k = 0; k < 4; k++) begin
					if (k > 0 && $urandom_range(99) < 12) begin
						post_sample(seq[k], 1'b0);
						post_sample(seq[k-1], 1'b0);
						made += 2;
					end
					post_sample(seq[k], $urandom_range(99) < 3);
					made++;
				end
			end else if (r < 88) begin
				// break off the turn and fall back to rest
				for (int k = 0; k < $urandom_range(1, 3); k++) begin
					post_sample(seq[k], $urandom_range(99) < 3);
					made++;
				end
				post_sample(2'd3, 1'b0);
				made++;
			end else begin
				post_sample(2'($urandom_range(3)), $urandom_range(99) < 5);
				made++;
			end
		end
	endtask

	// Wait for all requests to be taken and all results checked, then let the pipe empty.
	task automatic settle_knob();
		while (samples_unaccepted != 0 || knob_results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic run_batch(input int n, input int unsigned cw_pct, input int mode);
		case (mode % 4)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
			default: begin src_idle_pct = 26; sink_stall_pct = 26; end
		endcase
		queue_turns(n, cw_pct);
		settle_knob();
	endtask

	initial begin
		int lo_r;
		int hi_r;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: opening samples without idling, then random turns
		foreach (OPENING[i]) begin
			post_sample(OPENING[i][1:0], OPENING[i][2]);
		end
		settle_knob();
		run_batch(40, 60, 1);

		// small range with wrap, exact limits reachable
		apply_setting(-32'sd300, 32'sd300, 16'd100, 1'b1, 1'b0, 32'd0);
		run_batch(50, 50, 2);
		// full range, largest step, hold near the top with swapped direction
		apply_setting(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b1,
			32'h7fff_ffff - 32'd200000);
		run_batch(45, 20, 3);
		// full range with wrap, drive downward through the bottom
		apply_setting(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b1, 1'b0,
			32'h8000_0000 + 32'd100000);
		run_batch(45, 20, 0);
		// empty range, wrap and hold
		apply_setting(32'sd500, -32'sd500, 16'd7, 1'b1, 1'b1, 32'd0);
		run_batch(45, 50, 1);
		apply_setting(32'sd500, -32'sd500, 16'd7, 1'b0, 1'b0, 32'd3);
		run_batch(30, 50, 2);
		// setpoint preset outside the range
		apply_setting(32'sd1000, 32'sd2000, 16'd1, 1'b0, 1'b0, -32'sd5000);
		run_batch(40, 50, 3);
		// zero step moves nothing
		apply_setting(-32'sd1000, 32'sd1000, 16'd0, 1'b1, 1'b0, 32'd17);
		run_batch(30, 50, 0);
		// arbitrary register values
		for (int b = 0; b < 3; b++) begin
			apply_setting($urandom, $urandom, 16'($urandom_range(1, 65535)),
				1'($urandom), 1'($urandom), $urandom);
			run_batch(40, 50, b + 1);
		end
		// random narrow ranges where limits are hit often
		for (int b = 0; b < 2; b++) begin
			lo_r = -$urandom_range(0, 5000);
			hi_r = $urandom_range(0, 5000);
			apply_setting(lo_r, hi_r, 16'($urandom_range(1, 3000)),
				1'($urandom), 1'($urandom), 32'd0);
			run_batch(45, $urandom_range(20, 80), b);
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
